FILE: src/joint_limit_avoidance_drive_top_macros.svh
// Assertion macros for the joint limit avoidance drive.
`ifndef JOINT_LIMIT_AVOIDANCE_DRIVE_TOP_MACROS_SVH
`define JOINT_LIMIT_AVOIDANCE_DRIVE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define JLAD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define JLAD_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define JLAD_ASSERT(lbl, clk, rstn, prop)
`define JLAD_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: src/jlad_pkg.sv
// Package with widths, codes and sideband types of the joint limit avoidance drive.
package jlad_pkg;
    localparam int POS_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int OPND_W     = 17;
    localparam int SUM_W      = 18;
    localparam int PROD_W     = 34;
    localparam int MANT_W     = 32;
    localparam int LOG_INT_W  = 5;
    localparam int LOG_FRAC_W = 24;
    localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
    localparam int LNMAG_W    = 29;
    localparam int T_W        = SUM_W + LNMAG_W;
    localparam int NUM_W      = T_W + GAIN_W;
    localparam int DEN_W      = PROD_W + 4;
    localparam int Q_W        = 32;
    localparam int DRIVE_W    = 32;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [DRIVE_W-1:0] FULL_SCALE = 32'h7FFF_FFFF;

    localparam logic [1:0] CODE_NORMAL = 2'd0;
    localparam logic [1:0] CODE_INV    = 2'd1;
    localparam logic [1:0] CODE_LOW    = 2'd2;
    localparam logic [1:0] CODE_HIGH   = 2'd3;

    localparam logic [1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
    localparam logic [1:0] REG_GAIN       = 2'd2;

    typedef struct packed {
        logic [1:0]           code;
        logic [OPND_W-1:0]    a;
        logic [OPND_W-1:0]    b;
        logic [LOG_INT_W-1:0] na;
        logic [LOG_INT_W-1:0] nb;
    } sq_side_t;

    typedef struct packed {
        logic [1:0] code;
        logic       pos_log;
    } div_side_t;
endpackage

FILE: src/jlad_sq_cell.sv
// One squaring cell of the log2 chain: yields one fraction bit for each operand.
module jlad_sq_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [jlad_pkg::MANT_W-1:0]         in_ma,
    input  logic [jlad_pkg::MANT_W-1:0]         in_mb,
    input  logic [jlad_pkg::LOG_FRAC_W-1:0]     in_fa,
    input  logic [jlad_pkg::LOG_FRAC_W-1:0]     in_fb,
    input  jlad_pkg::sq_side_t                  in_side,
    output logic                                out_valid,
    output logic [jlad_pkg::MANT_W-1:0]         out_ma,
    output logic [jlad_pkg::MANT_W-1:0]         out_mb,
    output logic [jlad_pkg::LOG_FRAC_W-1:0]     out_fa,
    output logic [jlad_pkg::LOG_FRAC_W-1:0]     out_fb,
    output jlad_pkg::sq_side_t                  out_side
);
    localparam int MW = jlad_pkg::MANT_W;
    localparam int FW = jlad_pkg::LOG_FRAC_W;

    logic              valid_reg;
    logic [MW-1:0]     ma_reg, mb_reg, ma_next, mb_next;
    logic [FW-1:0]     fa_reg, fb_reg, fa_next, fb_next;
    jlad_pkg::sq_side_t side_reg;
    logic [2*MW-1:0]   pa, pb;
    logic [MW:0]       sa, sb;

    always_comb begin
        pa = in_ma * in_ma;
        pb = in_mb * in_mb;
        sa = pa[2*MW-1:MW-1];
        sb = pb[2*MW-1:MW-1];
        if (sa[MW]) begin
            ma_next = sa[MW:1];
            fa_next = {in_fa[FW-2:0], 1'b1};
        end else begin
            ma_next = sa[MW-1:0];
            fa_next = {in_fa[FW-2:0], 1'b0};
        end
        if (sb[MW]) begin
            mb_next = sb[MW:1];
            fb_next = {in_fb[FW-2:0], 1'b1};
        end else begin
            mb_next = sb[MW-1:0];
            fb_next = {in_fb[FW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            fa_reg   <= fa_next;
            fb_reg   <= fb_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_ma    = ma_reg;
    assign out_mb    = mb_reg;
    assign out_fa    = fa_reg;
    assign out_fb    = fb_reg;
    assign out_side  = side_reg;
endmodule

FILE: src/jlad_div_cell.sv
// One restoring division cell: yields one quotient bit at a fixed weight.
module jlad_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [jlad_pkg::NUM_W-1:0]      in_rem,
    input  logic [jlad_pkg::DEN_W-1:0]      in_den,
    input  logic [jlad_pkg::Q_W-1:0]        in_q,
    input  jlad_pkg::div_side_t             in_side,
    output logic                            out_valid,
    output logic [jlad_pkg::NUM_W-1:0]      out_rem,
    output logic [jlad_pkg::DEN_W-1:0]      out_den,
    output logic [jlad_pkg::Q_W-1:0]        out_q,
    output jlad_pkg::div_side_t             out_side
);
    localparam int NW  = jlad_pkg::NUM_W;
    localparam int DW  = jlad_pkg::DEN_W;
    localparam int QW  = jlad_pkg::Q_W;
    localparam int CW  = DW + QW - 1;

    logic                valid_reg;
    logic [NW-1:0]       rem_reg, rem_next;
    logic [DW-1:0]       den_reg;
    logic [QW-1:0]       q_reg, q_next;
    jlad_pkg::div_side_t side_reg;
    logic [CW-1:0]       wrem, dsh, diff;
    logic                take;

    always_comb begin
        wrem     = {{(CW-NW){1'b0}}, in_rem};
        dsh      = {{(CW-DW){1'b0}}, in_den} << SHIFT;
        diff     = wrem - dsh;
        take     = (wrem >= dsh);
        rem_next = take ? diff[NW-1:0] : in_rem;
        q_next   = {in_q[QW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;
endmodule

FILE: src/joint_limit_avoidance_drive_top.sv
// Top level of the joint limit avoidance drive pipeline.
//
// One position beat on the s_ channel gives one drive beat on the m_ channel.
// The low limit, high limit and gain are written on the cfg_ channel with
// index 0, 1 and 2; other indexes are ignored. cfg_ready is always high, and
// writes are expected only while no beat is in flight.
// The pipeline is a front stage, a chain of 24 squaring cells for the two
// log2 operands, four arithmetic stages, a chain of 32 division cells and an
// output register. A new beat is accepted every cycle unless the receiver
// stalls; the division chain, one quotient bit per cell, sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle.
// Reset, synchronous and active low, empties the pipeline and sets the
// limits to -4.0 and +4.0 rad and the gain to 1.0.
// m_tuser carries limit_flag: position at or beyond a limit, or limits
// inverted, with the drive at full scale toward the midpoint or zero.
`include "joint_limit_avoidance_drive_top_macros.svh"
module joint_limit_avoidance_drive_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // position[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drive[31:0]
    output logic [0:0]  m_tuser,   // limit_flag[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int OW  = jlad_pkg::OPND_W;
    localparam int MW  = jlad_pkg::MANT_W;
    localparam int FW  = jlad_pkg::LOG_FRAC_W;
    localparam int IW  = jlad_pkg::LOG_INT_W;
    localparam int LW  = jlad_pkg::LOG_W;
    localparam int NSQ = jlad_pkg::LOG_FRAC_W;
    localparam int NDV = jlad_pkg::Q_W;
    localparam int QW  = jlad_pkg::Q_W;

    logic signed [15:0] low_reg, high_reg;
    logic [15:0]        gain_reg;
    logic               en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= -16'sd16384;
            high_reg <= 16'sd16384;
            gain_reg <= 16'd256;
        end else if (cfg_valid) begin
            case (cfg_index)
                jlad_pkg::REG_LOW_LIMIT:  low_reg  <= cfg_data;
                jlad_pkg::REG_HIGH_LIMIT: high_reg <= cfg_data;
                jlad_pkg::REG_GAIN:       gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Front stage: case decode, operands and log2 normalization.
    logic signed [15:0] pos;
    logic [OW-1:0]      a_c, b_c;
    logic [1:0]         code_c;
    logic [IW-1:0]      na_c, nb_c;
    logic [MW-1:0]      ma_c, mb_c;

    always_comb begin
        pos = s_tdata;
        a_c = {pos[15], pos} - {low_reg[15], low_reg};
        b_c = {high_reg[15], high_reg} - {pos[15], pos};
        if (high_reg <= low_reg) begin
            code_c = jlad_pkg::CODE_INV;
        end else if (pos <= low_reg) begin
            code_c = jlad_pkg::CODE_LOW;
        end else if (pos >= high_reg) begin
            code_c = jlad_pkg::CODE_HIGH;
        end else begin
            code_c = jlad_pkg::CODE_NORMAL;
        end
        na_c = '0;
        nb_c = '0;
        for (int i = 0; i < OW; i++) begin
            if (a_c[i]) na_c = IW'(i);
            if (b_c[i]) nb_c = IW'(i);
        end
        ma_c = {{(MW-OW){1'b0}}, a_c} << (IW'(MW-1) - na_c);
        mb_c = {{(MW-OW){1'b0}}, b_c} << (IW'(MW-1) - nb_c);
    end

    logic               sq_valid [0:NSQ];
    logic [MW-1:0]      sq_ma    [0:NSQ];
    logic [MW-1:0]      sq_mb    [0:NSQ];
    logic [FW-1:0]      sq_fa    [0:NSQ];
    logic [FW-1:0]      sq_fb    [0:NSQ];
    jlad_pkg::sq_side_t sq_side  [0:NSQ];

    logic               fr_valid_reg;
    logic [MW-1:0]      fr_ma_reg, fr_mb_reg;
    jlad_pkg::sq_side_t fr_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else if (en) begin
            fr_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fr_ma_reg        <= ma_c;
            fr_mb_reg        <= mb_c;
            fr_side_reg.code <= code_c;
            fr_side_reg.a    <= a_c;
            fr_side_reg.b    <= b_c;
            fr_side_reg.na   <= na_c;
            fr_side_reg.nb   <= nb_c;
        end
    end

    assign sq_valid[0] = fr_valid_reg;
    assign sq_ma[0]    = fr_ma_reg;
    assign sq_mb[0]    = fr_mb_reg;
    assign sq_fa[0]    = '0;
    assign sq_fb[0]    = '0;
    assign sq_side[0]  = fr_side_reg;

    for (genvar g = 0; g < NSQ; g++) begin : g_sq
        jlad_sq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[g]),
            .in_ma     (sq_ma[g]),
            .in_mb     (sq_mb[g]),
            .in_fa     (sq_fa[g]),
            .in_fb     (sq_fb[g]),
            .in_side   (sq_side[g]),
            .out_valid (sq_valid[g+1]),
            .out_ma    (sq_ma[g+1]),
            .out_mb    (sq_mb[g+1]),
            .out_fa    (sq_fa[g+1]),
            .out_fb    (sq_fb[g+1]),
            .out_side  (sq_side[g+1])
        );
    end

    // Stage L1: log difference.
    logic [LW-1:0] la, lb;
    logic          l1_valid_reg, l1_pos_reg;
    logic [LW-1:0] l1_dmag_reg;
    logic [1:0]    l1_code_reg;
    logic [OW-1:0] l1_a_reg, l1_b_reg;

    assign la = {sq_side[NSQ].na, sq_fa[NSQ]};
    assign lb = {sq_side[NSQ].nb, sq_fb[NSQ]};

    // Stage L2: ln magnitude, a+b and a*b.
    logic [LW+31:0]                      lnprod;
    logic                                l2_valid_reg, l2_pos_reg;
    logic [jlad_pkg::LNMAG_W-1:0]        l2_ln_reg;
    logic [jlad_pkg::SUM_W-1:0]          l2_sum_reg;
    logic [jlad_pkg::PROD_W-1:0]         l2_ab_reg;
    logic [1:0]                          l2_code_reg;

    assign lnprod = ({32'd0, l1_dmag_reg} * {{LW{1'b0}}, jlad_pkg::LN2_Q32})
                    + (LW+32)'(64'h8000_0000);

    // Stage L3 and L4: numerator products.
    logic                                l3_valid_reg, l3_pos_reg;
    logic [jlad_pkg::T_W-1:0]            l3_t_reg;
    logic [jlad_pkg::PROD_W-1:0]         l3_ab_reg;
    logic [1:0]                          l3_code_reg;
    logic                                l4_valid_reg;
    logic [jlad_pkg::NUM_W-1:0]          l4_num_reg;
    logic [jlad_pkg::DEN_W-1:0]          l4_den_reg;
    jlad_pkg::div_side_t                 l4_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_valid_reg <= 1'b0;
            l2_valid_reg <= 1'b0;
            l3_valid_reg <= 1'b0;
            l4_valid_reg <= 1'b0;
        end else if (en) begin
            l1_valid_reg <= sq_valid[NSQ];
            l2_valid_reg <= l1_valid_reg;
            l3_valid_reg <= l2_valid_reg;
            l4_valid_reg <= l3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_pos_reg  <= (la > lb);
            l1_dmag_reg <= (la > lb) ? (la - lb) : (lb - la);
            l1_code_reg <= sq_side[NSQ].code;
            l1_a_reg    <= sq_side[NSQ].a;
            l1_b_reg    <= sq_side[NSQ].b;

            l2_pos_reg  <= l1_pos_reg;
            l2_code_reg <= l1_code_reg;
            l2_ln_reg   <= lnprod[32 +: jlad_pkg::LNMAG_W];
            l2_sum_reg  <= {1'b0, l1_a_reg} + {1'b0, l1_b_reg};
            l2_ab_reg   <= {{OW{1'b0}}, l1_a_reg} * {{OW{1'b0}}, l1_b_reg};

            l3_pos_reg  <= l2_pos_reg;
            l3_code_reg <= l2_code_reg;
            l3_ab_reg   <= l2_ab_reg;
            l3_t_reg    <= {{jlad_pkg::LNMAG_W{1'b0}}, l2_sum_reg}
                           * {{jlad_pkg::SUM_W{1'b0}}, l2_ln_reg};

            l4_side_reg.code    <= l3_code_reg;
            l4_side_reg.pos_log <= l3_pos_reg;
            l4_den_reg  <= {l3_ab_reg, 4'b0000};
            l4_num_reg  <= {{jlad_pkg::GAIN_W{1'b0}}, l3_t_reg}
                           * {{jlad_pkg::T_W{1'b0}}, gain_reg};
        end
    end

    logic                       dv_valid [0:NDV];
    logic [jlad_pkg::NUM_W-1:0] dv_rem   [0:NDV];
    logic [jlad_pkg::DEN_W-1:0] dv_den   [0:NDV];
    logic [QW-1:0]              dv_q     [0:NDV];
    jlad_pkg::div_side_t        dv_side  [0:NDV];

    assign dv_valid[0] = l4_valid_reg;
    assign dv_rem[0]   = l4_num_reg;
    assign dv_den[0]   = l4_den_reg;
    assign dv_q[0]     = '0;
    assign dv_side[0]  = l4_side_reg;

    for (genvar g = 0; g < NDV; g++) begin : g_dv
        jlad_div_cell #(.SHIFT(NDV - 1 - g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_valid[g]),
            .in_rem    (dv_rem[g]),
            .in_den    (dv_den[g]),
            .in_q      (dv_q[g]),
            .in_side   (dv_side[g]),
            .out_valid (dv_valid[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_den   (dv_den[g+1]),
            .out_q     (dv_q[g+1]),
            .out_side  (dv_side[g+1])
        );
    end

    // Output stage: saturation, sign and special cases.
    logic [31:0] mag, drive_c;
    logic        flag_c;
    logic [31:0] drive_reg;
    logic        flag_reg;

    always_comb begin
        mag = dv_q[NDV][QW-1] ? jlad_pkg::FULL_SCALE : {1'b0, dv_q[NDV][QW-2:0]};
        case (dv_side[NDV].code)
            jlad_pkg::CODE_NORMAL: begin
                drive_c = dv_side[NDV].pos_log ? (32'd0 - mag) : mag;
                flag_c  = 1'b0;
            end
            jlad_pkg::CODE_INV: begin
                drive_c = '0;
                flag_c  = 1'b1;
            end
            jlad_pkg::CODE_LOW: begin
                drive_c = jlad_pkg::FULL_SCALE;
                flag_c  = 1'b1;
            end
            default: begin
                drive_c = 32'd0 - jlad_pkg::FULL_SCALE;
                flag_c  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid[NDV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            drive_reg <= drive_c;
            flag_reg  <= flag_c;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = drive_reg;
    assign m_tuser[0] = flag_reg;

    `JLAD_ASSERT(a_flag_full_or_zero, aclk, aresetn, m_tvalid && m_tuser[0] |-> (m_tdata == 32'h0 || m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0001))
    `JLAD_ASSERT(a_no_min_value, aclk, aresetn, m_tvalid |-> m_tdata != 32'h8000_0000)
    `JLAD_ASSERT_NR(a_reset_empties, aclk, !aresetn |=> !m_tvalid)
endmodule
